// File: hdl/wodo_pkg.sv
// Shared types, constants and microcode table of the wheel odometry integrator.
package wodo_pkg;

   // request and response field widths
   localparam int NowWidth    = 32;
   localparam int RpmWidth    = 20;
   localparam int AgeWidth    = 16;
   localparam int FlagCount   = 5;
   localparam int SeqWidth    = 32;
   localparam int TsWidth     = 32;
   localparam int PosWidth    = 48;
   localparam int SpeedWidth  = 23;
   localparam int ReqBits     = NowWidth + RpmWidth + FlagCount + AgeWidth;
   localparam int ReqDataWidth = ((ReqBits + 7) / 8) * 8;
   localparam int RspBits     = SeqWidth + TsWidth + PosWidth + SpeedWidth + 1;
   localparam int RspDataWidth = ((RspBits + 7) / 8) * 8;

   // configuration registers
   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth  = 16;
   localparam int CircWidth     = 12;
   localparam logic [CsrIndexWidth-1:0] CSR_PERIOD = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_STALE  = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_CIRC   = 2'd2;
   localparam logic [15:0] PERIOD_RESET = 16'd20;
   localparam logic [15:0] STALE_RESET  = 16'd100;
   localparam logic [CircWidth-1:0] CIRC_RESET = 12'd200;

   // divide by 960 = shift by 6, then divide by 15 four quotient bits per step
   localparam int PreShift     = 6;
   localparam int DivWidth     = 60;
   localparam int DigitsPerStep = 4;
   localparam int DivSteps     = DivWidth / DigitsPerStep;
   localparam int RemWidth     = 4;
   localparam logic [RemWidth:0] DIVISOR = 5'd15;
   localparam int CntWidth     = $clog2(DivSteps);
   localparam logic [CntWidth-1:0] CNT_START = CntWidth'(DivSteps - 1);

   localparam int ProdWidth  = 32;
   localparam int Prod2Width = 64;
   localparam int IncWidth   = 56;
   localparam logic [15:0] US_PER_MS = 16'd1000;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_TAKE,
      OP_CHECK,
      OP_MUL,
      OP_DIV,
      OP_SPD,
      OP_ACC,
      OP_PUB
   } op_type;

   typedef enum logic [2:0] {
      COND_NONE,
      COND_ALWAYS,
      COND_NO_REQ,
      COND_EARLY,
      COND_CNT_NZ,
      COND_RSP_BUSY
   } cond_type;

   localparam int PcWidth = 4;

   typedef struct packed {
      op_type               op;
      cond_type             cond;
      logic [PcWidth-1:0]   target;
      logic                 cnt_load;
   } ucode_type;

   // datapath status seen by the sequencer
   typedef struct packed {
      logic early;
      logic rsp_busy;
   } dp_status_type;

   localparam logic [PcWidth-1:0] STEP_TAKE    = 4'd0;
   localparam logic [PcWidth-1:0] STEP_DIV_SPD = 4'd3;
   localparam logic [PcWidth-1:0] STEP_DIV_POS = 4'd5;
   localparam logic [PcWidth-1:0] STEP_PUB     = 4'd7;

   function automatic ucode_type ucode_rom(input logic [PcWidth-1:0] pc);
      ucode_type w;
      w = '{op: OP_NOP, cond: COND_ALWAYS, target: STEP_TAKE, cnt_load: 1'b0};
      case (pc)
         4'd0: w = '{op: OP_TAKE,  cond: COND_NO_REQ,   target: STEP_TAKE,    cnt_load: 1'b0};
         4'd1: w = '{op: OP_CHECK, cond: COND_NONE,     target: STEP_TAKE,    cnt_load: 1'b0};
         4'd2: w = '{op: OP_MUL,   cond: COND_EARLY,    target: STEP_TAKE,    cnt_load: 1'b1};
         4'd3: w = '{op: OP_DIV,   cond: COND_CNT_NZ,   target: STEP_DIV_SPD, cnt_load: 1'b0};
         4'd4: w = '{op: OP_SPD,   cond: COND_NONE,     target: STEP_TAKE,    cnt_load: 1'b1};
         4'd5: w = '{op: OP_DIV,   cond: COND_CNT_NZ,   target: STEP_DIV_POS, cnt_load: 1'b0};
         4'd6: w = '{op: OP_ACC,   cond: COND_NONE,     target: STEP_TAKE,    cnt_load: 1'b0};
         4'd7: w = '{op: OP_PUB,   cond: COND_RSP_BUSY, target: STEP_PUB,     cnt_load: 1'b0};
         default: w = '{op: OP_NOP, cond: COND_ALWAYS, target: STEP_TAKE, cnt_load: 1'b0};
      endcase
      return w;
   endfunction

endpackage

// File: hdl/wodo_div.sv
// Serial divide-by-15 unit, four quotient bits per cycle while step is asserted.
module wodo_div (
   input  logic                            clock,
   input  logic                            load,
   input  logic [wodo_pkg::DivWidth-1:0]   dividend,
   input  logic                            step,
   output logic [wodo_pkg::DivWidth-1:0]   quotient
);

   logic [wodo_pkg::DivWidth-1:0] q_ff, q_in;
   logic [wodo_pkg::RemWidth-1:0] r_ff, r_in;

   always_comb begin
      logic [wodo_pkg::RemWidth:0] r5;
      logic                        qbit;
      r5   = '0;
      qbit = 1'b0;
      q_in = q_ff;
      r_in = r_ff;
      if (load) begin
         q_in = dividend;
         r_in = '0;
      end else if (step) begin
         for (int i = 0; i < wodo_pkg::DigitsPerStep; i++) begin
            r5   = {r_in, q_in[wodo_pkg::DivWidth-1]};
            qbit = (r5 >= wodo_pkg::DIVISOR);
            r_in = qbit ? 4'(r5 - wodo_pkg::DIVISOR) : r5[wodo_pkg::RemWidth-1:0];
            q_in = {q_in[wodo_pkg::DivWidth-2:0], qbit};
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
   end

   assign quotient = q_ff;

endmodule

// File: hdl/wodo_datapath.sv
// Datapath: config registers, multipliers, accumulator and response register.
module wodo_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  wodo_pkg::op_type                      op,
   output wodo_pkg::dp_status_type               status,
   input  logic                                  csr_wr_en,
   input  logic [wodo_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [wodo_pkg::CsrDataWidth-1:0]     csr_wdata,
   input  logic                                  req_tvalid,
   input  logic [wodo_pkg::ReqDataWidth-1:0]     req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [wodo_pkg::RspDataWidth-1:0]     rsp_tdata
);

   localparam int RpmLo = wodo_pkg::NowWidth;
   localparam int FlagLo = RpmLo + wodo_pkg::RpmWidth;
   localparam int AgeLo = FlagLo + wodo_pkg::FlagCount;

   logic [15:0]                      period_ff, period_in;
   logic [15:0]                      stale_ff, stale_in;
   logic [wodo_pkg::CircWidth-1:0]   circ_ff, circ_in;

   logic [wodo_pkg::NowWidth-1:0]    now_ff;
   logic [wodo_pkg::RpmWidth-1:0]    raw_ff;
   logic [wodo_pkg::FlagCount-1:0]   flags_ff;
   logic [wodo_pkg::AgeWidth-1:0]    age_ff;

   logic [wodo_pkg::NowWidth-1:0]    dt_ff;
   logic                             valid_ff;
   logic                             neg_ff;
   logic [wodo_pkg::ProdWidth-1:0]   prod1_ff;
   logic [wodo_pkg::Prod2Width-1:0]  prod2_ff;
   logic [wodo_pkg::SpeedWidth-1:0]  speed_ff;

   logic [wodo_pkg::PosWidth-1:0]    acc_ff, acc_in;
   logic [wodo_pkg::NowWidth-1:0]    last_ff, last_in;
   logic [wodo_pkg::SeqWidth-1:0]    count_ff, count_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic [wodo_pkg::RspDataWidth-1:0] rsp_data_ff;

   logic                             take, publish;
   logic [wodo_pkg::RpmWidth-1:0]    rmag;
   logic [wodo_pkg::SeqWidth-1:0]    seq_next;
   logic [wodo_pkg::TsWidth-1:0]     ts;

   logic                             div_load, div_step;
   logic [wodo_pkg::DivWidth-1:0]    div_dividend, quotient;

   logic [wodo_pkg::IncWidth-1:0]    inc, sum;
   logic [wodo_pkg::SpeedWidth:0]    speed_mag;

   assign status.rsp_busy = rsp_valid_ff & ~rsp_tready;
   assign status.early    = (dt_ff < {16'b0, period_ff});

   assign take    = (op == wodo_pkg::OP_TAKE) & req_tvalid;
   assign publish = (op == wodo_pkg::OP_PUB) & ~status.rsp_busy;

   // config
   always_comb begin
      period_in = period_ff;
      stale_in  = stale_ff;
      circ_in   = circ_ff;
      if (csr_wr_en) begin
         case (csr_index)
            wodo_pkg::CSR_PERIOD: period_in = csr_wdata;
            wodo_pkg::CSR_STALE:  stale_in  = csr_wdata;
            wodo_pkg::CSR_CIRC:   circ_in   = csr_wdata[wodo_pkg::CircWidth-1:0];
            default: ;
         endcase
      end
   end

   assign rmag = raw_ff[wodo_pkg::RpmWidth-1] ? (~raw_ff + 1'b1) : raw_ff;

   // shared divider: speed dividend after the first multiply, distance after the second
   assign div_load = (op == wodo_pkg::OP_MUL) | (op == wodo_pkg::OP_SPD);
   assign div_step = (op == wodo_pkg::OP_DIV);
   assign div_dividend = (op == wodo_pkg::OP_MUL) ?
      wodo_pkg::DivWidth'(prod1_ff[wodo_pkg::ProdWidth-1:wodo_pkg::PreShift]) :
      wodo_pkg::DivWidth'(prod2_ff[wodo_pkg::Prod2Width-1:wodo_pkg::PreShift]);

   wodo_div u_div (
      .clock    (clock),
      .load     (div_load),
      .dividend (div_dividend),
      .step     (div_step),
      .quotient (quotient)
   );

   // speed never exceeds the 23-bit range: 2^19 * 4095 / 960 < 2^22
   assign speed_mag = quotient[wodo_pkg::SpeedWidth:0];

   assign inc = neg_ff ? (~quotient[wodo_pkg::IncWidth-1:0] + 1'b1)
                       : quotient[wodo_pkg::IncWidth-1:0];
   assign sum = {{(wodo_pkg::IncWidth-wodo_pkg::PosWidth){acc_ff[wodo_pkg::PosWidth-1]}},
                 acc_ff} + inc;

   always_comb begin
      acc_in = acc_ff;
      if ((op == wodo_pkg::OP_ACC) && valid_ff) begin
         if (sum[wodo_pkg::IncWidth-1:wodo_pkg::PosWidth-1] == '0 ||
             sum[wodo_pkg::IncWidth-1:wodo_pkg::PosWidth-1] == '1) begin
            acc_in = sum[wodo_pkg::PosWidth-1:0];
         end else if (sum[wodo_pkg::IncWidth-1]) begin
            acc_in = {1'b1, {(wodo_pkg::PosWidth-1){1'b0}}};
         end else begin
            acc_in = {1'b0, {(wodo_pkg::PosWidth-1){1'b1}}};
         end
      end
   end

   assign seq_next = (count_ff + 1'b1 == '0) ? wodo_pkg::SeqWidth'(1) : count_ff + 1'b1;
   assign ts = wodo_pkg::TsWidth'(now_ff * wodo_pkg::US_PER_MS);

   always_comb begin
      last_in      = last_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      if (publish) begin
         last_in      = now_ff;
         count_in     = seq_next;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff    <= wodo_pkg::PERIOD_RESET;
         stale_ff     <= wodo_pkg::STALE_RESET;
         circ_ff      <= wodo_pkg::CIRC_RESET;
         acc_ff       <= '0;
         last_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         period_ff    <= period_in;
         stale_ff     <= stale_in;
         circ_ff      <= circ_in;
         acc_ff       <= acc_in;
         last_ff      <= last_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         now_ff   <= req_tdata[RpmLo-1:0];
         raw_ff   <= req_tdata[FlagLo-1:RpmLo];
         flags_ff <= req_tdata[AgeLo-1:FlagLo];
         age_ff   <= req_tdata[AgeLo+wodo_pkg::AgeWidth-1:AgeLo];
      end
      if (op == wodo_pkg::OP_CHECK) begin
         dt_ff    <= now_ff - last_ff;
         valid_ff <= (&flags_ff) && (age_ff <= stale_ff) && (circ_ff != '0);
         neg_ff   <= raw_ff[wodo_pkg::RpmWidth-1];
         prod1_ff <= wodo_pkg::ProdWidth'(rmag) * wodo_pkg::ProdWidth'(circ_ff);
      end
      if (op == wodo_pkg::OP_MUL) begin
         prod2_ff <= wodo_pkg::Prod2Width'(prod1_ff) * wodo_pkg::Prod2Width'(dt_ff);
      end
      if (op == wodo_pkg::OP_SPD) begin
         if (!valid_ff) begin
            speed_ff <= '0;
         end else if (neg_ff) begin
            speed_ff <= wodo_pkg::SpeedWidth'(~speed_mag + 1'b1);
         end else begin
            speed_ff <= speed_mag[wodo_pkg::SpeedWidth-1:0];
         end
      end
      if (publish) begin
         rsp_data_ff <= wodo_pkg::RspDataWidth'({valid_ff, speed_ff, acc_ff, ts, seq_next});
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: hdl/wodo_sequencer.sv
// Microcode sequencer: step counter, control ROM, loop counter and jump logic.
module wodo_sequencer (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   input  wodo_pkg::dp_status_type     status,
   output wodo_pkg::op_type            op
);

   logic [wodo_pkg::PcWidth-1:0]  pc_ff, pc_in;
   logic [wodo_pkg::CntWidth-1:0] cnt_ff, cnt_in;
   wodo_pkg::ucode_type           uw;
   logic                          jump;

   assign uw = wodo_pkg::ucode_rom(pc_ff);
   assign op = uw.op;

   always_comb begin
      case (uw.cond)
         wodo_pkg::COND_NONE:     jump = 1'b0;
         wodo_pkg::COND_ALWAYS:   jump = 1'b1;
         wodo_pkg::COND_NO_REQ:   jump = ~req_tvalid;
         wodo_pkg::COND_EARLY:    jump = status.early;
         wodo_pkg::COND_CNT_NZ:   jump = (cnt_ff != '0);
         wodo_pkg::COND_RSP_BUSY: jump = status.rsp_busy;
         default:                 jump = 1'b1;
      endcase
   end

   always_comb begin
      pc_in  = jump ? uw.target : pc_ff + 1'b1;
      cnt_in = cnt_ff;
      if (uw.cnt_load) begin
         cnt_in = wodo_pkg::CNT_START;
      end else if (uw.op == wodo_pkg::OP_DIV) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff  <= wodo_pkg::STEP_TAKE;
         cnt_ff <= '0;
      end else begin
         pc_ff  <= pc_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// File: hdl/wheel_odometry_integrator_top.sv
// Top level of the wheel odometry integrator.
//
// One request per millisecond tick: time stamp, signed wheel speed, health flags
// and sample age. When at least period_ms has passed since the last publish, one
// response carries sequence number, time in us, integrated distance in um, speed
// in mm/s and a valid flag; otherwise the request produces no response.
// A request is accepted only while the sequencer sits at its fetch step. An early
// request is dropped at the multiply step and the sequencer returns to fetch. A
// publishing request passes the check, multiply, divide, speed, divide and
// accumulate steps before its publish step writes the response register; each of
// the two serial divide-by-15 passes takes four quotient bits a cycle.
// An idle step follows; no request is taken before the last is done. The response
// sits in an output register; if the receiver stalls with a response still
// pending, the sequencer holds at its publish step until the register frees.
// Reset (synchronous) clears distance, last publish time and count and restores
// the config defaults (20 ms, 100 ms, 200 mm).
// Config writes (csr_wr_en, csr_index, csr_wdata) take effect at once.
module wheel_odometry_integrator_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [wodo_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [wodo_pkg::CsrDataWidth-1:0]   csr_wdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // now_ms[31:0], wheel_rpm_q4[51:32], balance_present[52], wheel_present[53],
   // motor_online[54], left_motor_ok[55], right_motor_ok[56], sample_age_ms[72:57]
   input  logic [wodo_pkg::ReqDataWidth-1:0]   req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // sequence_number[31:0], stamp_us[63:32], position_um[111:64],
   // speed_mm_s[134:112], odometry_valid[135]
   output logic [wodo_pkg::RspDataWidth-1:0]   rsp_tdata
);

   wodo_pkg::op_type        op;
   wodo_pkg::dp_status_type status;

   assign req_tready = (op == wodo_pkg::OP_TAKE);

   wodo_sequencer u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .status     (status),
      .op         (op)
   );

   wodo_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .op         (op),
      .status     (status),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// File: tb/tb_wheel_odometry_integrator_top.sv
// Self-checking testbench for the wheel odometry integrator top level.
`timescale 1ns / 100ps

module tb_wheel_odometry_integrator_top;

   localparam int SettleCycles = 64;     // covers an early request still being dropped
   localparam int QuietLimit   = 5000;   // cycles with no handshake before giving up
   localparam int PhaseRequests = 300;
   localparam logic [4:0] AllHealthy = 5'b11111;
   localparam longint PosMax = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint PosMin = -64'sh0000_8000_0000_0000;
   localparam longint SpeedMax = 64'sd4194303;
   localparam longint SpeedMin = -64'sd4194304;

   // health bits from bit 0: balance, wheel, motor, left, right
   typedef struct {
      logic [31:0] now_ms;
      logic [19:0] rpm_q4;
      logic [4:0]  health;
      logic [15:0] age_ms;
   } wheel_sample_type;

   // laid out as rsp_tdata: sequence number in the lowest bits
   typedef struct packed {
      logic        valid;
      logic [22:0] speed;
      logic [47:0] pos;
      logic [31:0] ts;
      logic [31:0] seq;
   } odo_publish_type;

   logic                                clock = 1'b0;
   logic                                reset;
   logic                                csr_wr_en;
   logic [wodo_pkg::CsrIndexWidth-1:0]  csr_index;
   logic [wodo_pkg::CsrDataWidth-1:0]   csr_wdata;
   logic                                req_tvalid;
   logic                                req_tready;
   // now_ms, wheel_rpm_q4, balance_present, wheel_present, motor_online,
   // left_motor_ok, right_motor_ok, sample_age_ms
   logic [wodo_pkg::ReqDataWidth-1:0]   req_tdata;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   // sequence_number, stamp_us, position_um, speed_mm_s, odometry_valid
   logic [wodo_pkg::RspDataWidth-1:0]   rsp_tdata;

   // predictor state and configuration
   logic [15:0] cfg_period;
   logic [15:0] cfg_stale;
   logic [11:0] cfg_circ;
   longint      odo_distance;
   logic [31:0] odo_last_ms;
   logic [31:0] odo_count;

   odo_publish_type pending_publishes[$];
   odo_publish_type want, seen;
   int          error_count = 0;
   int          quiet_cycles = 0;
   int          burst_left = 0;
   bit          gaps_on = 1'b1;
   int          stall_left = 0;
   logic [9:0]  rx_cycle = '0;

   wheel_odometry_integrator_top dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // works out the publish (if any) caused by one accepted request
   task automatic predict_publish(input wheel_sample_type s);
      logic [31:0]  dt;
      logic [19:0]  rmag;
      logic [63:0]  mag;
      longint       step, sum, spd;
      bit           neg, ok;
      odo_publish_type r;
      dt = s.now_ms - odo_last_ms;
      if (dt < 32'(cfg_period)) return;
      odo_last_ms = s.now_ms;
      neg = s.rpm_q4[19];
      rmag = neg ? (~s.rpm_q4 + 20'd1) : s.rpm_q4;
      ok = (&s.health) && (s.age_ms <= cfg_stale) && (cfg_circ != '0);
      spd = 0;
      if (ok) begin
         mag = 64'(rmag) * 64'(dt) * 64'(cfg_circ);
         step = longint'(mag / 64'd960);
         if (neg) step = -step;
         sum = odo_distance + step;
         odo_distance = (sum > PosMax) ? PosMax : (sum < PosMin) ? PosMin : sum;
         spd = longint'((64'(rmag) * 64'(cfg_circ)) / 64'd960);
         if (neg) spd = -spd;
         spd = (spd > SpeedMax) ? SpeedMax : (spd < SpeedMin) ? SpeedMin : spd;
      end
      odo_count = odo_count + 32'd1;
      if (odo_count == '0) odo_count = 32'd1;
      r.seq   = odo_count;
      r.ts    = s.now_ms * 32'd1000;
      r.pos   = odo_distance[47:0];
      r.speed = spd[22:0];
      r.valid = ok;
      pending_publishes.push_back(r);
   endtask

   function automatic wheel_sample_type make_sample(input logic [31:0] now,
                                                    input logic [19:0] rpm,
                                                    input logic [4:0] health,
                                                    input logic [15:0] age);
      wheel_sample_type s;
      s.now_ms = now;
      s.rpm_q4 = rpm;
      s.health = health;
      s.age_ms = age;
      return s;
   endfunction

   // mostly well-timed healthy ticks, some early ones, some pure noise
   function automatic wheel_sample_type random_sample();
      wheel_sample_type s;
      int          kind;
      logic [31:0] dt;
      kind = $urandom_range(0, 99);
      s.rpm_q4 = 20'($urandom);
      if ($urandom_range(0, 9) == 0) s.rpm_q4 = $urandom_range(0, 1) ? 20'h7FFFF : 20'h80000;
      s.health = ($urandom_range(0, 6) == 0) ? 5'($urandom) : AllHealthy;
      if ($urandom_range(0, 4) == 0 || cfg_stale == 16'hFFFF) s.age_ms = 16'($urandom);
      else s.age_ms = 16'($urandom_range(0, int'(cfg_stale) + 1));
      if (kind < 8) begin
         s.now_ms = $urandom;
         s.health = 5'($urandom);
      end else if (kind < 25 && cfg_period != '0) begin
         s.now_ms = odo_last_ms + 32'($urandom_range(0, int'(cfg_period) - 1));
      end else begin
         dt = 32'(cfg_period) + (($urandom_range(0, 19) == 0) ? 32'($urandom_range(0, 100000))
                                                               : 32'($urandom_range(0, 30)));
         s.now_ms = odo_last_ms + dt;
      end
      return s;
   endfunction

   task automatic send_sample(input wheel_sample_type s);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = gaps_on ? $urandom_range(0, 12) : 0;
         repeat (gap) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
         end
      end
      burst_left--;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= wodo_pkg::ReqDataWidth'({s.age_ms, s.health, s.rpm_q4, s.now_ms});
      do @(posedge clock); while (req_tready !== 1'b1);
      predict_publish(s);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_publishes.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic csr_write(input logic [wodo_pkg::CsrIndexWidth-1:0] idx,
                            input logic [15:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         wodo_pkg::CSR_PERIOD: cfg_period = val;
         wodo_pkg::CSR_STALE:  cfg_stale  = val;
         wodo_pkg::CSR_CIRC:   cfg_circ   = val[wodo_pkg::CircWidth-1:0];
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [15:0] period, input logic [15:0] stale,
                             input logic [15:0] circ);
      wait_drained();
      csr_write(wodo_pkg::CSR_PERIOD, period);
      csr_write(wodo_pkg::CSR_STALE, stale);
      csr_write(wodo_pkg::CSR_CIRC, circ);
   endtask

   // reset defaults: early drops, stale limit edges, each health flag, time wrap
   task automatic test_default_config();
      send_sample(make_sample(32'd0, 20'h00000, AllHealthy, 16'd0));
      send_sample(make_sample(32'd19, 20'h7FFFF, AllHealthy, 16'd0));
      send_sample(make_sample(32'd20, 20'h7FFFF, AllHealthy, 16'd100));
      send_sample(make_sample(32'd40, 20'h80000, AllHealthy, 16'd101));
      for (int i = 0; i < 5; i++)
         send_sample(make_sample(32'(60 + 20 * i), 20'h12345, AllHealthy ^ 5'(1 << i), 16'd0));
      send_sample(make_sample(32'd200, 20'hFFFFF, AllHealthy, 16'hFFFF));
      send_sample(make_sample(32'd230, 20'hFFFFF, AllHealthy, 16'd0));
      // long jump then wrap of the millisecond counter and of the us stamp
      send_sample(make_sample(32'hFFFF_FFF0, 20'h00000, AllHealthy, 16'd0));
      send_sample(make_sample(32'h0000_0010, 20'h00001, AllHealthy, 16'd0));
   endtask

   // period zero: a repeated stamp still publishes, distance stays put
   task automatic test_zero_elapsed();
      set_config(16'd0, 16'hFFFF, 16'd4095);
      send_sample(make_sample(32'd1000, 20'h40000, AllHealthy, 16'hFFFF));
      send_sample(make_sample(32'd1000, 20'h40000, AllHealthy, 16'hFFFF));
      send_sample(make_sample(32'd1000, 20'hC0000, 5'b01111, 16'd0));
   endtask

   task automatic test_circumference_limits();
      set_config(16'd1, 16'd0, 16'd0);
      send_sample(make_sample(32'd2000, 20'h7FFFF, AllHealthy, 16'd0));
      set_config(16'd1, 16'd0, 16'd1);
      send_sample(make_sample(32'd2001, 20'h7FFFF, AllHealthy, 16'd0));
      send_sample(make_sample(32'd2002, 20'h80000, AllHealthy, 16'd1));
      send_sample(make_sample(32'd2003, 20'h80000, AllHealthy, 16'd0));
   endtask

   task automatic test_random_traffic();
      logic [15:0] periods [5] = '{16'd20, 16'd0, 16'hFFFF, 16'd1, 16'd7};
      logic [15:0] stales  [5] = '{16'd100, 16'hFFFF, 16'd0, 16'd50, 16'd1000};
      logic [15:0] circs   [5] = '{16'd200, 16'd4095, 16'd1, 16'd0, 16'd1234};
      for (int phase = 0; phase < 6; phase++) begin
         if (phase < 5) set_config(periods[phase], stales[phase], circs[phase]);
         else set_config(16'($urandom_range(0, 60)), 16'($urandom), 16'($urandom_range(0, 4095)));
         gaps_on = (phase != 1);
         repeat (PhaseRequests) send_sample(random_sample());
      end
      gaps_on = 1'b1;
   endtask

   // near-full-range elapsed time drives the distance into both rails
   task automatic test_position_saturation();
      set_config(16'd0, 16'hFFFF, 16'd4095);
      repeat (2) send_sample(make_sample(odo_last_ms - 32'd1, 20'h7FFFF, AllHealthy, 16'd0));
      repeat (2) send_sample(make_sample(odo_last_ms - 32'd1, 20'h80000, AllHealthy, 16'd0));
      send_sample(make_sample(odo_last_ms + 32'd5, 20'h00100, AllHealthy, 16'd0));
   endtask

   // receiver stall pattern: quiet, short frequent, long rare, medium
   always @(negedge clock) begin
      rx_cycle <= rx_cycle + 10'd1;
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
         case (rx_cycle[9:8])
            2'd1: if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 3);
            2'd2: if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(10, 40);
            2'd3: if ($urandom_range(0, 1) == 0) stall_left = $urandom_range(1, 8);
            default: ;
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen = rsp_tdata;
         if (pending_publishes.size() == 0) begin
            $error("unexpected response: sequence_number %0d", seen.seq);
            error_count++;
         end else begin
            want = pending_publishes.pop_front();
            if (seen.seq !== want.seq) begin
               $error("sequence_number: expected %0d, got %0d", want.seq, seen.seq);
               error_count++;
            end
            if (seen.ts !== want.ts) begin
               $error("stamp_us: expected %0d, got %0d", want.ts, seen.ts);
               error_count++;
            end
            if (seen.pos !== want.pos) begin
               $error("position_um: expected %0d, got %0d", $signed(want.pos), $signed(seen.pos));
               error_count++;
            end
            if (seen.speed !== want.speed) begin
               $error("speed_mm_s: expected %0d, got %0d",
                      $signed(want.speed), $signed(seen.speed));
               error_count++;
            end
            if (seen.valid !== want.valid) begin
               $error("odometry_valid: expected %0d, got %0d", want.valid, seen.valid);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
         $display("** wheel_odometry_integrator_top: FAILED **");
         $finish;
      end
   end

   initial begin
      reset      = 1'b1;
      csr_wr_en  = 1'b0;
      csr_index  = wodo_pkg::CSR_PERIOD;
      csr_wdata  = '0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      cfg_period   = wodo_pkg::PERIOD_RESET;
      cfg_stale    = wodo_pkg::STALE_RESET;
      cfg_circ     = wodo_pkg::CIRC_RESET;
      odo_distance = 0;
      odo_last_ms  = '0;
      odo_count    = '0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      test_default_config();
      test_zero_elapsed();
      test_circumference_limits();
      test_random_traffic();
      test_position_saturation();
      wait_drained();

      if (error_count == 0)
         $display("** wheel_odometry_integrator_top: PASSED **");
      else
         $display("** wheel_odometry_integrator_top: FAILED **");
      $finish;
   end

endmodule
